/* hw/rtl/vss_pkg.sv */
// Shared types, constants and helpers of the slew-limited vector smoother.
package vss_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MIN_STEP_LENGTH = 1;
  localparam int SHORT_TICK_MUL  = 1000;   // elapsed * 1000 below one second unit means a short tick

  localparam int VAL_W   = 32;
  localparam int SLEW_W  = 40;
  localparam int ET_W    = 20;
  localparam int D_W     = 34;             // axis step, signed
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FT_W    = FRAC_BITS + 1;
  localparam int Q_W     = 31;
  localparam int LEN_W   = 33;
  localparam int CAP_W   = 45;
  localparam int ROOT_W  = 34;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int DEN_W   = 34;
  localparam int NUM_W   = LEN_W + FRAC_BITS;
  localparam int CNT_W   = 6;
  localparam int SPLIT   = 24;             // operand split for wide products

  localparam logic [CNT_W-1:0] DIV_LEN_E_STEPS = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] DIV_FRAC_STEPS  = CNT_W'(Q_W);
  localparam logic [CNT_W-1:0] SQRT_STEPS      = CNT_W'(ROOT_W);

  localparam logic [VAL_W-1:0]  TIME_GAIN_RST = 32'd262144;
  localparam logic [SLEW_W-1:0] SLEW_GAIN_RST = 40'd262144;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_HOLD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_TIME_GAIN = 2'd0,
    CFG_SLEW_GAIN = 2'd1,
    CFG_SMOOTH_EN = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] in_x;
    logic signed [VAL_W-1:0] in_y;
    logic signed [VAL_W-1:0] in_z;
    logic [ET_W-1:0]         elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [VAL_W-1:0]        out_speed;
  } out_item_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_TG, MUL_D_FT, MUL_D_Q, MUL_SQ,
    MUL_SLEW_HI, MUL_SLEW_LO, MUL_CAP_HI, MUL_CAP_LO
  } mul_sel_t;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_SET, CAP_CLEAR, CAP_DIFF, CAP_FT, CAP_D16, CAP_D31,
    CAP_ACC_SET, CAP_ACC_ADD, CAP_ACC_HI, CAP_LEN, CAP_CAP, CAP_Q,
    CAP_NEW, CAP_SNAP, CAP_COMMIT
  } cap_sel_t;

  typedef enum logic {
    DIV_LEN_E,
    DIV_FRAC
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic [1:0] mul_idx;
    cap_sel_t cap_sel;
    logic [1:0] cap_idx;
    logic     sqrt_start;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic short_tick;
    logic smooth_en;
    logic len_big;
    logic rate_over;
    logic sqrt_done;
    logic div_done;
  } dp_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH, ST_FT_MUL, ST_FT_GET,
    ST_AX0, ST_AX1, ST_AX2, ST_AX3,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT_GO, ST_SQRT_WAIT, ST_LEN_CHK,
    ST_SL0, ST_SL1, ST_SL2, ST_CAP, ST_RATE_WAIT,
    ST_AL0, ST_AL1, ST_AL2, ST_Q_GO, ST_Q_WAIT,
    ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_NEW, ST_SNAP,
    ST_SPD_GO, ST_SPD_WAIT, ST_OUT
  } ctrl_state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+2:0] v);
    logic signed [VAL_W+2:0] hi;
    logic signed [VAL_W+2:0] lo;
    hi = (VAL_W+3)'(2147483647);
    lo = -hi - (VAL_W+3)'(1);
    if (v > hi) return VAL_W'(hi);
    else if (v < lo) return VAL_W'(lo);
    else return VAL_W'(v);
  endfunction

endpackage

/* hw/rtl/vector_smoother_slew_limited.sv */
// Top level of the slew-limited 3D vector smoother: configuration registers and units.
// Each item is one operation on a Q16.16 position: an update tick moves it toward the
// goal by min(elapsed*time_gain, 1) of the distance, limited by the current speed plus
// slew_gain*elapsed, and returns the new position and speed; set and clear go straight
// to the result, as does an update tick shorter than a millisecond. An update's time is
// set by the radix-2 square root unit (one length per run, run twice in a smoothed
// update) and the radix-2 divider (each speed quotient, and the scale fraction when the
// slew limit shortens the step), with a shared 34x34 multiplier doing the rest; a tiny
// step snaps to the goal. One item is worked on at a time; a finished result waits in
// the output register while the next item is taken. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module vector_smoother_slew_limited (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vss_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vss_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [vss_pkg::SLEW_W-1:0]   cfg_wdata
);

  logic [vss_pkg::VAL_W-1:0]  time_gain_r;
  logic [vss_pkg::SLEW_W-1:0] slew_gain_r;
  logic                       smooth_en_r;

  vss_pkg::dp_cmd_t  cmd;
  vss_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_gain_r <= vss_pkg::TIME_GAIN_RST;
      slew_gain_r <= vss_pkg::SLEW_GAIN_RST;
      smooth_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (vss_pkg::cfg_idx_t'(cfg_index))
        vss_pkg::CFG_TIME_GAIN: time_gain_r <= cfg_wdata[vss_pkg::VAL_W-1:0];
        vss_pkg::CFG_SLEW_GAIN: slew_gain_r <= cfg_wdata;
        vss_pkg::CFG_SMOOTH_EN: smooth_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  vss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  vss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .time_gain (time_gain_r),
    .slew_gain (slew_gain_r),
    .smooth_en (smooth_en_r),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/vss_sqrt.sv */
// Radix-2 restoring integer square root, one result bit per cycle.
module vss_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [vss_pkg::RAD_W-1:0]       radicand,
  output logic [vss_pkg::ROOT_W-1:0]      root,
  output logic                            done
);

  logic [vss_pkg::RAD_W-1:0]  rad_r;
  logic [vss_pkg::ROOT_W:0]   rem_r;
  logic [vss_pkg::ROOT_W-1:0] root_r;
  logic [vss_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [vss_pkg::ROOT_W+2:0] part;
  logic [vss_pkg::ROOT_W+2:0] trial;
  logic                       fits;

  assign part  = {rem_r, rad_r[vss_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = part >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= vss_pkg::SQRT_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == vss_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[vss_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? (vss_pkg::ROOT_W+1)'(part - trial) : (vss_pkg::ROOT_W+1)'(part);
      root_r <= {root_r[vss_pkg::ROOT_W-2:0], fits};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* hw/rtl/vss_div.sv */
// Radix-2 restoring unsigned divider with preset remainder and step count.
module vss_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vss_pkg::DEN_W-1:0]   rem0,
  input  logic [vss_pkg::NUM_W-1:0]   num0,
  input  logic [vss_pkg::DEN_W-1:0]   den,
  input  logic [vss_pkg::CNT_W-1:0]   steps,
  output logic [vss_pkg::NUM_W-1:0]   quot,
  output logic                        done
);

  logic [vss_pkg::DEN_W-1:0] rem_r;
  logic [vss_pkg::NUM_W-1:0] num_r;
  logic [vss_pkg::NUM_W-1:0] quot_r;
  logic [vss_pkg::DEN_W-1:0] den_r;
  logic [vss_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [vss_pkg::DEN_W:0] part;
  logic [vss_pkg::DEN_W:0] den_x;
  logic                    fits;

  assign part  = {rem_r, num_r[vss_pkg::NUM_W-1]};
  assign den_x = {1'b0, den_r};
  assign fits  = part >= den_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == vss_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem0;
      num_r  <= num0;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? vss_pkg::DEN_W'(part - den_x) : vss_pkg::DEN_W'(part);
      num_r  <= {num_r[vss_pkg::NUM_W-2:0], 1'b0};
      quot_r <= {quot_r[vss_pkg::NUM_W-2:0], fits};
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

/* hw/rtl/vss_dp.sv */
// Datapath: state, shared multiplier, square root and divider units.
module vss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vss_pkg::dp_cmd_t              cmd,
  input  vss_pkg::in_item_t             in_data,
  input  logic [vss_pkg::VAL_W-1:0]     time_gain,
  input  logic [vss_pkg::SLEW_W-1:0]    slew_gain,
  input  logic                          smooth_en,
  output vss_pkg::dp_stat_t             stat,
  output vss_pkg::out_item_t            out_data
);

  logic signed [vss_pkg::VAL_W-1:0] g_r   [3];
  logic signed [vss_pkg::VAL_W-1:0] cur_r [3];
  logic signed [vss_pkg::VAL_W-1:0] cur_nxt [3];
  logic signed [vss_pkg::VAL_W-1:0] n_r   [3];
  logic signed [vss_pkg::D_W-1:0]   d_r   [3];
  logic [vss_pkg::VAL_W-1:0]        speed_r;
  logic [vss_pkg::VAL_W-1:0]        speed_nxt;
  logic [vss_pkg::ET_W-1:0]         e_r;
  logic [1:0]                       op_r;
  logic [vss_pkg::FT_W-1:0]         ft_r;
  logic [vss_pkg::PROD_W-1:0]       acc_r;
  logic [vss_pkg::PROD_W-1:0]       prod_r;
  logic [vss_pkg::LEN_W-1:0]        len_r;
  logic [vss_pkg::CAP_W-1:0]        cap_r;
  logic [vss_pkg::Q_W-1:0]          q_r;
  vss_pkg::out_item_t               out_r;

  logic signed [vss_pkg::D_W-1:0]   diff   [3];
  logic signed [vss_pkg::VAL_W-1:0] sat_v  [3];
  logic signed [vss_pkg::D_W-1:0]   mv_d   [3];
  logic [vss_pkg::MUL_W-1:0]        mag    [3];
  logic [vss_pkg::MUL_W-1:0]        mul_a;
  logic [vss_pkg::MUL_W-1:0]        mul_b;
  logic [vss_pkg::MUL_W-1:0]        mag_m;
  logic [vss_pkg::LEN_W-1:0]        p16;
  logic [vss_pkg::LEN_W-1:0]        p31;
  logic [vss_pkg::D_W-1:0]          pick;
  logic                             neg_c;
  logic [35:0]                      ft_raw;
  logic [29:0]                      e_scaled;

  logic [vss_pkg::ROOT_W-1:0]       root;
  logic                             sqrt_done;
  logic [vss_pkg::NUM_W-1:0]        quot;
  logic                             div_done;
  logic [vss_pkg::DEN_W-1:0]        div_rem0;
  logic [vss_pkg::NUM_W-1:0]        div_num0;
  logic [vss_pkg::DEN_W-1:0]        div_den;
  logic [vss_pkg::CNT_W-1:0]        div_steps;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = vss_pkg::D_W'(g_r[i]) - vss_pkg::D_W'(cur_r[i]);
      sat_v[i] = vss_pkg::sat32((vss_pkg::VAL_W+3)'(cur_r[i]) + (vss_pkg::VAL_W+3)'(d_r[i]));
      mv_d[i]  = vss_pkg::D_W'(sat_v[i]) - vss_pkg::D_W'(cur_r[i]);
      mag[i]   = d_r[i][vss_pkg::D_W-1] ? vss_pkg::MUL_W'(-d_r[i]) : vss_pkg::MUL_W'(d_r[i]);
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mag_m = mag[cmd.mul_idx];
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      vss_pkg::MUL_TG: begin
        mul_a = vss_pkg::MUL_W'(time_gain);
        mul_b = vss_pkg::MUL_W'(e_r);
      end
      vss_pkg::MUL_D_FT: begin
        mul_a = mag_m;
        mul_b = vss_pkg::MUL_W'(ft_r);
      end
      vss_pkg::MUL_D_Q: begin
        mul_a = mag_m;
        mul_b = vss_pkg::MUL_W'(q_r);
      end
      vss_pkg::MUL_SQ: begin
        mul_a = mag_m;
        mul_b = mag_m;
      end
      vss_pkg::MUL_SLEW_HI: begin
        mul_a = vss_pkg::MUL_W'(slew_gain[vss_pkg::SLEW_W-1:vss_pkg::SPLIT]);
        mul_b = vss_pkg::MUL_W'(e_r);
      end
      vss_pkg::MUL_SLEW_LO: begin
        mul_a = vss_pkg::MUL_W'(slew_gain[vss_pkg::SPLIT-1:0]);
        mul_b = vss_pkg::MUL_W'(e_r);
      end
      vss_pkg::MUL_CAP_HI: begin
        mul_a = vss_pkg::MUL_W'(cap_r[vss_pkg::CAP_W-1:vss_pkg::SPLIT]);
        mul_b = vss_pkg::MUL_W'(e_r);
      end
      vss_pkg::MUL_CAP_LO: begin
        mul_a = vss_pkg::MUL_W'(cap_r[vss_pkg::SPLIT-1:0]);
        mul_b = vss_pkg::MUL_W'(e_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= vss_pkg::PROD_W'(mul_a) * vss_pkg::PROD_W'(mul_b);
  end

  // product rescaling, sign of the axis put back (truncation toward zero)
  assign p16   = prod_r[vss_pkg::FRAC_BITS +: vss_pkg::LEN_W];
  assign p31   = prod_r[vss_pkg::Q_W +: vss_pkg::LEN_W];
  assign neg_c = d_r[cmd.cap_idx][vss_pkg::D_W-1];
  assign ft_raw = prod_r[vss_pkg::FRAC_BITS +: 36];

  always_comb begin
    pick = (cmd.cap_sel == vss_pkg::CAP_D31) ? vss_pkg::D_W'(p31) : vss_pkg::D_W'(p16);
    if (neg_c) pick = vss_pkg::D_W'(0) - pick;
  end

  // architectural state
  always_comb begin
    cur_nxt   = cur_r;
    speed_nxt = speed_r;
    case (cmd.cap_sel)
      vss_pkg::CAP_SET: cur_nxt = g_r;
      vss_pkg::CAP_CLEAR: begin
        for (int i = 0; i < 3; i++) cur_nxt[i] = '0;
        speed_nxt = '0;
      end
      vss_pkg::CAP_COMMIT: begin
        cur_nxt   = n_r;
        speed_nxt = (quot[vss_pkg::NUM_W-1:vss_pkg::VAL_W] != '0) ? '1 :
                    quot[vss_pkg::VAL_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) cur_r[i] <= '0;
      speed_r <= '0;
    end else begin
      cur_r   <= cur_nxt;
      speed_r <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      g_r[0] <= in_data.in_x;
      g_r[1] <= in_data.in_y;
      g_r[2] <= in_data.in_z;
      e_r    <= in_data.elapsed_time;
      op_r   <= in_data.op;
    end
    case (cmd.cap_sel)
      vss_pkg::CAP_DIFF: d_r <= diff;
      vss_pkg::CAP_FT:
        ft_r <= (ft_raw > 36'(1 << vss_pkg::FRAC_BITS)) ?
                vss_pkg::FT_W'(1 << vss_pkg::FRAC_BITS) : ft_raw[vss_pkg::FT_W-1:0];
      vss_pkg::CAP_D16,
      vss_pkg::CAP_D31: d_r[cmd.cap_idx] <= pick;
      vss_pkg::CAP_ACC_SET: acc_r <= prod_r;
      vss_pkg::CAP_ACC_ADD: acc_r <= acc_r + prod_r;
      vss_pkg::CAP_ACC_HI:  acc_r <= prod_r << vss_pkg::SPLIT;
      vss_pkg::CAP_LEN:     len_r <= root[vss_pkg::LEN_W-1:0];
      vss_pkg::CAP_CAP:
        cap_r <= vss_pkg::CAP_W'(speed_r) + acc_r[vss_pkg::FRAC_BITS +: vss_pkg::CAP_W];
      vss_pkg::CAP_Q:       q_r <= quot[vss_pkg::Q_W-1:0];
      vss_pkg::CAP_NEW: begin
        n_r <= sat_v;
        d_r <= mv_d;
      end
      vss_pkg::CAP_SNAP: begin
        n_r <= g_r;
        d_r <= diff;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_r.out_x     <= cur_r[0];
      out_r.out_y     <= cur_r[1];
      out_r.out_z     <= cur_r[2];
      out_r.out_speed <= speed_r;
    end
  end

  vss_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (acc_r),
    .root     (root),
    .done     (sqrt_done)
  );

  always_comb begin
    if (cmd.div_sel == vss_pkg::DIV_FRAC) begin
      // allowed length is below the step length, so it is a valid start remainder
      div_rem0  = acc_r[vss_pkg::FRAC_BITS +: vss_pkg::DEN_W];
      div_num0  = '0;
      div_den   = vss_pkg::DEN_W'(len_r);
      div_steps = vss_pkg::DIV_FRAC_STEPS;
    end else begin
      div_rem0  = '0;
      div_num0  = {len_r, vss_pkg::FRAC_BITS'(0)};
      div_den   = vss_pkg::DEN_W'(e_r);
      div_steps = vss_pkg::DIV_LEN_E_STEPS;
    end
  end

  vss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .rem0  (div_rem0),
    .num0  (div_num0),
    .den   (div_den),
    .steps (div_steps),
    .quot  (quot),
    .done  (div_done)
  );

  assign e_scaled = 30'(e_r) * 30'(vss_pkg::SHORT_TICK_MUL);

  assign stat.op         = vss_pkg::op_t'(op_r);
  assign stat.short_tick = e_scaled < 30'(1 << vss_pkg::FRAC_BITS);
  assign stat.smooth_en  = smooth_en;
  assign stat.len_big    = len_r > vss_pkg::LEN_W'(vss_pkg::MIN_STEP_LENGTH);
  assign stat.rate_over  = quot > vss_pkg::NUM_W'(cap_r);
  assign stat.sqrt_done  = sqrt_done;
  assign stat.div_done   = div_done;

  assign out_data = out_r;

endmodule

/* hw/rtl/vss_ctrl.sv */
// Controller state machine sequencing the smoother datapath.
module vss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_stall,
  input  vss_pkg::dp_stat_t  stat,
  output logic               in_stall,
  output logic               out_valid,
  output vss_pkg::dp_cmd_t   cmd
);

  vss_pkg::ctrl_state_t state_r, state_nxt;
  logic pass_r, pass_nxt;     // second pass measures the actual move
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vss_pkg::ST_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    cmd.load_in    = 1'b0;
    cmd.mul_sel    = vss_pkg::MUL_NONE;
    cmd.mul_idx    = 2'd0;
    cmd.cap_sel    = vss_pkg::CAP_NONE;
    cmd.cap_idx    = 2'd0;
    cmd.sqrt_start = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.div_sel    = vss_pkg::DIV_LEN_E;
    cmd.out_load   = 1'b0;
    case (state_r)
      vss_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = vss_pkg::ST_DISPATCH;
        end
      end
      vss_pkg::ST_DISPATCH: begin
        pass_nxt = 1'b0;
        case (stat.op)
          vss_pkg::OP_UPDATE: begin
            if (stat.short_tick) state_nxt = vss_pkg::ST_OUT;
            else if (stat.smooth_en) begin
              cmd.cap_sel = vss_pkg::CAP_DIFF;
              state_nxt   = vss_pkg::ST_FT_MUL;
            end else state_nxt = vss_pkg::ST_SNAP;
          end
          vss_pkg::OP_SET: begin
            cmd.cap_sel = vss_pkg::CAP_SET;
            state_nxt   = vss_pkg::ST_OUT;
          end
          vss_pkg::OP_CLEAR: begin
            cmd.cap_sel = vss_pkg::CAP_CLEAR;
            state_nxt   = vss_pkg::ST_OUT;
          end
          default: state_nxt = vss_pkg::ST_OUT;
        endcase
      end
      vss_pkg::ST_FT_MUL: begin
        cmd.mul_sel = vss_pkg::MUL_TG;
        state_nxt   = vss_pkg::ST_FT_GET;
      end
      vss_pkg::ST_FT_GET: begin
        cmd.cap_sel = vss_pkg::CAP_FT;
        state_nxt   = vss_pkg::ST_AX0;
      end
      vss_pkg::ST_AX0: begin
        cmd.mul_sel = vss_pkg::MUL_D_FT;
        cmd.mul_idx = 2'd0;
        state_nxt   = vss_pkg::ST_AX1;
      end
      vss_pkg::ST_AX1: begin
        cmd.cap_sel = vss_pkg::CAP_D16;
        cmd.cap_idx = 2'd0;
        cmd.mul_sel = vss_pkg::MUL_D_FT;
        cmd.mul_idx = 2'd1;
        state_nxt   = vss_pkg::ST_AX2;
      end
      vss_pkg::ST_AX2: begin
        cmd.cap_sel = vss_pkg::CAP_D16;
        cmd.cap_idx = 2'd1;
        cmd.mul_sel = vss_pkg::MUL_D_FT;
        cmd.mul_idx = 2'd2;
        state_nxt   = vss_pkg::ST_AX3;
      end
      vss_pkg::ST_AX3: begin
        cmd.cap_sel = vss_pkg::CAP_D16;
        cmd.cap_idx = 2'd2;
        state_nxt   = vss_pkg::ST_SQ0;
      end
      vss_pkg::ST_SQ0: begin
        cmd.mul_sel = vss_pkg::MUL_SQ;
        cmd.mul_idx = 2'd0;
        state_nxt   = vss_pkg::ST_SQ1;
      end
      vss_pkg::ST_SQ1: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_SET;
        cmd.mul_sel = vss_pkg::MUL_SQ;
        cmd.mul_idx = 2'd1;
        state_nxt   = vss_pkg::ST_SQ2;
      end
      vss_pkg::ST_SQ2: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_ADD;
        cmd.mul_sel = vss_pkg::MUL_SQ;
        cmd.mul_idx = 2'd2;
        state_nxt   = vss_pkg::ST_SQ3;
      end
      vss_pkg::ST_SQ3: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_ADD;
        state_nxt   = vss_pkg::ST_SQRT_GO;
      end
      vss_pkg::ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = vss_pkg::ST_SQRT_WAIT;
      end
      vss_pkg::ST_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          cmd.cap_sel = vss_pkg::CAP_LEN;
          state_nxt   = pass_r ? vss_pkg::ST_SPD_GO : vss_pkg::ST_LEN_CHK;
        end
      end
      vss_pkg::ST_LEN_CHK: begin
        // tiny step snaps onto the goal
        state_nxt = stat.len_big ? vss_pkg::ST_SL0 : vss_pkg::ST_SNAP;
      end
      vss_pkg::ST_SL0: begin
        cmd.mul_sel = vss_pkg::MUL_SLEW_HI;
        state_nxt   = vss_pkg::ST_SL1;
      end
      vss_pkg::ST_SL1: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_HI;
        cmd.mul_sel = vss_pkg::MUL_SLEW_LO;
        state_nxt   = vss_pkg::ST_SL2;
      end
      vss_pkg::ST_SL2: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_ADD;
        state_nxt   = vss_pkg::ST_CAP;
      end
      vss_pkg::ST_CAP: begin
        cmd.cap_sel   = vss_pkg::CAP_CAP;
        cmd.div_start = 1'b1;
        cmd.div_sel   = vss_pkg::DIV_LEN_E;
        state_nxt     = vss_pkg::ST_RATE_WAIT;
      end
      vss_pkg::ST_RATE_WAIT: begin
        if (stat.div_done) state_nxt = stat.rate_over ? vss_pkg::ST_AL0 : vss_pkg::ST_NEW;
      end
      vss_pkg::ST_AL0: begin
        cmd.mul_sel = vss_pkg::MUL_CAP_HI;
        state_nxt   = vss_pkg::ST_AL1;
      end
      vss_pkg::ST_AL1: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_HI;
        cmd.mul_sel = vss_pkg::MUL_CAP_LO;
        state_nxt   = vss_pkg::ST_AL2;
      end
      vss_pkg::ST_AL2: begin
        cmd.cap_sel = vss_pkg::CAP_ACC_ADD;
        state_nxt   = vss_pkg::ST_Q_GO;
      end
      vss_pkg::ST_Q_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = vss_pkg::DIV_FRAC;
        state_nxt     = vss_pkg::ST_Q_WAIT;
      end
      vss_pkg::ST_Q_WAIT: begin
        cmd.div_sel = vss_pkg::DIV_FRAC;
        if (stat.div_done) begin
          cmd.cap_sel = vss_pkg::CAP_Q;
          state_nxt   = vss_pkg::ST_Q0;
        end
      end
      vss_pkg::ST_Q0: begin
        cmd.mul_sel = vss_pkg::MUL_D_Q;
        cmd.mul_idx = 2'd0;
        state_nxt   = vss_pkg::ST_Q1;
      end
      vss_pkg::ST_Q1: begin
        cmd.cap_sel = vss_pkg::CAP_D31;
        cmd.cap_idx = 2'd0;
        cmd.mul_sel = vss_pkg::MUL_D_Q;
        cmd.mul_idx = 2'd1;
        state_nxt   = vss_pkg::ST_Q2;
      end
      vss_pkg::ST_Q2: begin
        cmd.cap_sel = vss_pkg::CAP_D31;
        cmd.cap_idx = 2'd1;
        cmd.mul_sel = vss_pkg::MUL_D_Q;
        cmd.mul_idx = 2'd2;
        state_nxt   = vss_pkg::ST_Q3;
      end
      vss_pkg::ST_Q3: begin
        cmd.cap_sel = vss_pkg::CAP_D31;
        cmd.cap_idx = 2'd2;
        state_nxt   = vss_pkg::ST_NEW;
      end
      vss_pkg::ST_NEW: begin
        cmd.cap_sel = vss_pkg::CAP_NEW;
        pass_nxt    = 1'b1;
        state_nxt   = vss_pkg::ST_SQ0;
      end
      vss_pkg::ST_SNAP: begin
        cmd.cap_sel = vss_pkg::CAP_SNAP;
        pass_nxt    = 1'b1;
        state_nxt   = vss_pkg::ST_SQ0;
      end
      vss_pkg::ST_SPD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = vss_pkg::DIV_LEN_E;
        state_nxt     = vss_pkg::ST_SPD_WAIT;
      end
      vss_pkg::ST_SPD_WAIT: begin
        if (stat.div_done) begin
          cmd.cap_sel = vss_pkg::CAP_COMMIT;
          state_nxt   = vss_pkg::ST_OUT;
        end
      end
      vss_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = vss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vss_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = state_r != vss_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_sqrt_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sqrt_done |-> state_r == vss_pkg::ST_SQRT_WAIT)
    else $error("square root finished outside its wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == vss_pkg::ST_RATE_WAIT || state_r == vss_pkg::ST_Q_WAIT ||
                       state_r == vss_pkg::ST_SPD_WAIT))
    else $error("divider finished outside a wait state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == vss_pkg::ST_DISPATCH)
    else $error("item taken without dispatch");
`endif

endmodule
